>>> hw/rtl/pidc_pkg.sv
// pidc_pkg.sv: shared widths, codes, microcode ROM and fixed-point helpers
// for the PID step block. No dependencies; used by all pidc modules.

package pidc_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int OPB_WIDTH     = DATA_WIDTH + 1;
  localparam int PROD_WIDTH    = DATA_WIDTH + OPB_WIDTH;
  localparam int SUM_WIDTH     = DATA_WIDTH + 2;
  localparam int CFG_COUNT     = 8;
  localparam int CFG_IDX_WIDTH = $clog2(CFG_COUNT);
  localparam int PC_WIDTH      = 4;

  localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [PROD_WIDTH:0] RND_POS =
    {{(PROD_WIDTH-FRAC_BITS+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [PROD_WIDTH:0] RND_NEG = RND_POS - (PROD_WIDTH+1)'(1);

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_TRACK  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_KP, CFG_KI_HALF_T, CFG_D_GAIN, CFG_D_POLE,
    CFG_TRACKING_GAIN, CFG_OUT_MIN, CFG_OUT_MAX, CFG_INT_LIMIT
  } cfg_idx_t;

  typedef enum logic [2:0] {MA_KP, MA_KI, MA_DG, MA_DP, MA_TG} mula_t;
  typedef enum logic [2:0] {MB_ESUM, MB_MDIFF, MB_DST, MB_ERR, MB_ADIFF} mulb_t;

  typedef enum logic [2:0] {
    ALU_NOP, ALU_ERR, ALU_NEGQ, ALU_DNEW, ALU_INTQ, ALU_SUM, ALU_DRIVE, ALU_CLR
  } alu_t;

  typedef enum logic [1:0] {JC_NEXT, JC_END, JC_END_TG_OFF} jc_t;

  typedef struct packed {
    logic  ld_op;
    mula_t mul_a;
    mulb_t mul_b;
    alu_t  alu;
    jc_t   jc;
  } ucode_t;

  typedef struct packed {
    logic  load_in;
    logic  load_out;
    logic  ld_op;
    mula_t mul_a;
    mulb_t mul_b;
    alu_t  alu;
  } dp_ctl_t;

  typedef struct packed {
    logic tg_on;
  } dp_stat_t;

  localparam logic [PC_WIDTH-1:0] UC_UPDATE = PC_WIDTH'(0);
  localparam logic [PC_WIDTH-1:0] UC_TRACK  = PC_WIDTH'(8);
  localparam logic [PC_WIDTH-1:0] UC_CLEAR  = PC_WIDTH'(12);
  localparam logic [PC_WIDTH-1:0] UC_IDLE   = PC_WIDTH'(13);

  function automatic ucode_t uc(input logic ld, input mula_t a, input mulb_t b,
                                input alu_t op, input jc_t j);
    ucode_t w;
    w.ld_op = ld;
    w.mul_a = a;
    w.mul_b = b;
    w.alu   = op;
    w.jc    = j;
    return w;
  endfunction

  // Product pipeline: operands loaded at a step pass through the operand, product and rounding registers to q.
  function automatic ucode_t ucode_rom(input logic [PC_WIDTH-1:0] pc);
    ucode_t w;
    unique case (pc)
      UC_UPDATE:                  w = uc(1'b1, MA_DG, MB_MDIFF, ALU_ERR,   JC_NEXT);
      UC_UPDATE + PC_WIDTH'(1):   w = uc(1'b1, MA_DP, MB_DST,   ALU_NOP,   JC_NEXT);
      UC_UPDATE + PC_WIDTH'(2):   w = uc(1'b1, MA_KI, MB_ESUM,  ALU_NOP,   JC_NEXT);
      UC_UPDATE + PC_WIDTH'(3):   w = uc(1'b1, MA_KP, MB_ERR,   ALU_NEGQ,  JC_NEXT);
      UC_UPDATE + PC_WIDTH'(4):   w = uc(1'b0, MA_KP, MB_ERR,   ALU_DNEW,  JC_NEXT);
      UC_UPDATE + PC_WIDTH'(5):   w = uc(1'b0, MA_KP, MB_ERR,   ALU_INTQ,  JC_NEXT);
      UC_UPDATE + PC_WIDTH'(6):   w = uc(1'b0, MA_KP, MB_ERR,   ALU_SUM,   JC_NEXT);
      UC_UPDATE + PC_WIDTH'(7):   w = uc(1'b0, MA_KP, MB_ERR,   ALU_DRIVE, JC_END);
      UC_TRACK:                   w = uc(1'b1, MA_TG, MB_ADIFF, ALU_NOP,   JC_END_TG_OFF);
      UC_TRACK + PC_WIDTH'(1):    w = uc(1'b0, MA_TG, MB_ADIFF, ALU_NOP,   JC_NEXT);
      UC_TRACK + PC_WIDTH'(2):    w = uc(1'b0, MA_TG, MB_ADIFF, ALU_NOP,   JC_NEXT);
      UC_TRACK + PC_WIDTH'(3):    w = uc(1'b0, MA_TG, MB_ADIFF, ALU_INTQ,  JC_END);
      UC_CLEAR:                   w = uc(1'b0, MA_KP, MB_ERR,   ALU_CLR,   JC_END);
      default:                    w = uc(1'b0, MA_KP, MB_ERR,   ALU_NOP,   JC_END);
    endcase
    return w;
  endfunction

  function automatic logic [PC_WIDTH-1:0] entry_pc(input logic [1:0] req);
    logic [PC_WIDTH-1:0] a;
    unique case (req)
      REQ_UPDATE: a = UC_UPDATE;
      REQ_TRACK:  a = UC_TRACK;
      REQ_CLEAR:  a = UC_CLEAR;
      default:    a = UC_IDLE;
    endcase
    return a;
  endfunction

  function automatic logic [SUM_WIDTH-1:0] sx(input logic [DATA_WIDTH-1:0] v);
    return {{(SUM_WIDTH-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

  function automatic logic [DATA_WIDTH-1:0] sat_sum(input logic [SUM_WIDTH-1:0] v);
    logic [SUM_WIDTH-DATA_WIDTH:0] top;
    top = v[SUM_WIDTH-1:DATA_WIDTH-1];
    if ((&top) || !(|top)) return v[DATA_WIDTH-1:0];
    return v[SUM_WIDTH-1] ? VMIN : VMAX;
  endfunction

  // Shift right by FRAC_BITS, round half away from zero, saturate.
  function automatic logic [DATA_WIDTH-1:0] qround(input logic [PROD_WIDTH-1:0] p);
    logic [PROD_WIDTH:0] s;
    logic signed [PROD_WIDTH:0] sh;
    logic [PROD_WIDTH-DATA_WIDTH+1:0] top;
    s   = {p[PROD_WIDTH-1], p} + (p[PROD_WIDTH-1] ? RND_NEG : RND_POS);
    sh  = $signed(s) >>> FRAC_BITS;
    top = sh[PROD_WIDTH:DATA_WIDTH-1];
    if ((&top) || !(|top)) return sh[DATA_WIDTH-1:0];
    return sh[PROD_WIDTH] ? VMIN : VMAX;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] clamp_int(input logic [DATA_WIDTH-1:0] v,
                                                       input logic [DATA_WIDTH-2:0] lim);
    logic signed [DATA_WIDTH:0] vx;
    logic signed [DATA_WIDTH:0] lp;
    logic signed [DATA_WIDTH:0] ln;
    vx = {v[DATA_WIDTH-1], v};
    lp = {2'b00, lim};
    ln = -lp;
    if (vx > lp) return lp[DATA_WIDTH-1:0];
    if (vx < ln) return ln[DATA_WIDTH-1:0];
    return v;
  endfunction

endpackage

>>> hw/rtl/pidc_seq.sv
// pidc_seq.sv: microcode sequencer for the PID step block: step counter,
// dispatch, conditional end, item handshakes. Depends on pidc_pkg.

module pidc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  pidc_pkg::dp_stat_t            stat,
  output pidc_pkg::dp_ctl_t             ctl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_POST = 3'b100
  } seq_state_t;

  seq_state_t                       state;
  logic [pidc_pkg::PC_WIDTH-1:0]    pc;
  pidc_pkg::ucode_t                 uw;
  logic                             run;
  logic                             end_now;
  logic                             in_accept;
  logic                             load_out;

  assign uw        = pidc_pkg::ucode_rom(pc);
  assign run       = (state == ST_RUN);
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_out  = (state == ST_POST) && (!out_valid || !out_stall);

  always_comb begin
    end_now = 1'b0;
    if (run) begin
      unique case (uw.jc)
        pidc_pkg::JC_NEXT:       end_now = 1'b0;
        pidc_pkg::JC_END:        end_now = 1'b1;
        pidc_pkg::JC_END_TG_OFF: end_now = !stat.tg_on;
        default:                 end_now = 1'b1;
      endcase
    end
  end

  always_comb begin
    ctl.load_in  = in_accept;
    ctl.load_out = load_out;
    ctl.ld_op    = run && uw.ld_op;
    ctl.mul_a    = uw.mul_a;
    ctl.mul_b    = uw.mul_b;
    ctl.alu      = run ? uw.alu : pidc_pkg::ALU_NOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            pc    <= pidc_pkg::entry_pc(req_type);
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (end_now) state <= ST_POST;
          else pc <= pc + pidc_pkg::PC_WIDTH'(1);
        end
        ST_POST: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_result_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_POST))
    else $error("result raised outside post state");

  a_post_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && out_valid && out_stall) |=> state == ST_POST)
    else $error("post state left while output register full");

  a_run_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |=> (state == ST_RUN || state == ST_POST))
    else $error("program run left without post state");
`endif

endmodule

>>> hw/rtl/pidc_dp.sv
// pidc_dp.sv: PID datapath: config registers, controller state, shared
// multiplier with rounding pipeline, ALU, output register. Uses pidc_pkg.

module pidc_dp (
  input  logic                                      clk,
  input  logic                                      rst,
  input  pidc_pkg::dp_ctl_t                         ctl,
  output pidc_pkg::dp_stat_t                        stat,
  input  logic                                      cfg_we,
  input  logic [pidc_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
  input  logic [pidc_pkg::DATA_WIDTH-1:0]           cfg_data,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0]    setpoint,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0]    measurement,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0]    actual_output,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    drive,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    p_term,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    i_term,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    d_term
);

  localparam int DW = pidc_pkg::DATA_WIDTH;

  logic signed [DW-1:0] kp, ki_half_t, d_gain, d_pole, tracking_gain, out_min, out_max;
  logic [DW-2:0]        int_limit;

  logic signed [DW-1:0] integ, perr, pmeas, dstate, pstate, ldrive;
  logic signed [DW-1:0] sp_r, meas_r, act_r, err, q;
  logic [pidc_pkg::SUM_WIDTH-1:0]          acc;
  logic signed [DW-1:0]                    opa, opa_next;
  logic signed [pidc_pkg::OPB_WIDTH-1:0]   opb, opb_next;
  logic signed [pidc_pkg::PROD_WIDTH-1:0]  prod;
  logic signed [DW-1:0] dsat, lo, hi, drive_cl;

  assign stat.tg_on = (tracking_gain > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp            <= '0;
      ki_half_t     <= '0;
      d_gain        <= '0;
      d_pole        <= '0;
      tracking_gain <= '0;
      out_min       <= pidc_pkg::VMIN;
      out_max       <= pidc_pkg::VMAX;
      int_limit     <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidc_pkg::CFG_KP:            kp            <= cfg_data;
        pidc_pkg::CFG_KI_HALF_T:     ki_half_t     <= cfg_data;
        pidc_pkg::CFG_D_GAIN:        d_gain        <= cfg_data;
        pidc_pkg::CFG_D_POLE:        d_pole        <= cfg_data;
        pidc_pkg::CFG_TRACKING_GAIN: tracking_gain <= cfg_data;
        pidc_pkg::CFG_OUT_MIN:       out_min       <= cfg_data;
        pidc_pkg::CFG_OUT_MAX:       out_max       <= cfg_data;
        pidc_pkg::CFG_INT_LIMIT:     int_limit     <= cfg_data[DW-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ctl.mul_a)
      pidc_pkg::MA_KP: opa_next = kp;
      pidc_pkg::MA_KI: opa_next = ki_half_t;
      pidc_pkg::MA_DG: opa_next = d_gain;
      pidc_pkg::MA_DP: opa_next = d_pole;
      pidc_pkg::MA_TG: opa_next = tracking_gain;
      default:         opa_next = kp;
    endcase
    unique case (ctl.mul_b)
      pidc_pkg::MB_ESUM:  opb_next = {err[DW-1], err} + {perr[DW-1], perr};
      pidc_pkg::MB_MDIFF: opb_next = {meas_r[DW-1], meas_r} - {pmeas[DW-1], pmeas};
      pidc_pkg::MB_DST:   opb_next = {dstate[DW-1], dstate};
      pidc_pkg::MB_ERR:   opb_next = {err[DW-1], err};
      pidc_pkg::MB_ADIFF: opb_next = {act_r[DW-1], act_r} - {ldrive[DW-1], ldrive};
      default:            opb_next = {err[DW-1], err};
    endcase
  end

  // operand -> product -> rounded product, one register each
  always_ff @(posedge clk) begin
    if (ctl.ld_op) begin
      opa <= opa_next;
      opb <= opb_next;
    end
    prod <= opa * opb;
    q    <= pidc_pkg::qround(prod);
  end

  always_comb begin
    dsat = pidc_pkg::sat_sum(acc);
    if (out_min > out_max) begin
      lo = out_max;
      hi = out_min;
    end else begin
      lo = out_min;
      hi = out_max;
    end
    drive_cl = dsat;
    if (dsat > hi) drive_cl = hi;
    else if (dsat < lo) drive_cl = lo;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      sp_r   <= setpoint;
      meas_r <= measurement;
      act_r  <= actual_output;
    end
    unique case (ctl.alu)
      pidc_pkg::ALU_ERR:  err <= pidc_pkg::sat_sum(pidc_pkg::sx(sp_r) - pidc_pkg::sx(meas_r));
      pidc_pkg::ALU_NEGQ: acc <= pidc_pkg::SUM_WIDTH'(0) - pidc_pkg::sx(q);
      pidc_pkg::ALU_SUM:  acc <= pidc_pkg::sx(q) + pidc_pkg::sx(integ) + pidc_pkg::sx(dstate);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ  <= '0;
      perr   <= '0;
      pmeas  <= '0;
      dstate <= '0;
      pstate <= '0;
      ldrive <= '0;
    end else begin
      unique case (ctl.alu)
        pidc_pkg::ALU_NOP, pidc_pkg::ALU_ERR, pidc_pkg::ALU_NEGQ: ;
        pidc_pkg::ALU_DNEW: begin
          dstate <= (d_gain == 0) ? '0 : pidc_pkg::sat_sum(acc - pidc_pkg::sx(q));
        end
        pidc_pkg::ALU_INTQ: begin
          integ <= pidc_pkg::clamp_int(
                     pidc_pkg::sat_sum(pidc_pkg::sx(integ) + pidc_pkg::sx(q)), int_limit);
        end
        pidc_pkg::ALU_SUM: pstate <= q;
        pidc_pkg::ALU_DRIVE: begin
          ldrive <= drive_cl;
          perr   <= err;
          pmeas  <= meas_r;
        end
        pidc_pkg::ALU_CLR: begin
          integ  <= '0;
          perr   <= '0;
          pmeas  <= '0;
          dstate <= '0;
          pstate <= '0;
          ldrive <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      drive  <= ldrive;
      p_term <= pstate;
      i_term <= integ;
      d_term <= dstate;
    end
  end

`ifndef SYNTHESIS
  a_int_in_limit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(ctl.alu == pidc_pkg::ALU_INTQ)) |->
      ($signed({integ[DW-1], integ}) <= $signed({2'b00, int_limit}) &&
       $signed({integ[DW-1], integ}) >= -$signed({2'b00, int_limit})))
    else $error("integrator outside its limit after update");
`endif

endmodule

>>> hw/rtl/pid_controller_step.sv
// pid_controller_step.sv: top level of the Q16.16 PID step block.
// Instantiates pidc_seq and pidc_dp; uses pidc_pkg.

// One item in, one result item out. An update item takes 8 microcode steps on
// a single shared 33x32 multiplier (operand, product and rounding registers,
// overlapped across steps), then loads the output register, which sets
// out_valid; the next item is taken only after that load. Back-calculation
// takes 4 steps, or ends after its first step when tracking_gain is not
// positive; clear and the unused code each take a single step. A stalled
// output holds the block until the output register can be loaded. Configuration
// writes go straight to their registers and must be made while no item is in
// flight.

module pid_controller_step (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [pidc_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
  input  logic [pidc_pkg::DATA_WIDTH-1:0]           cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [1:0]                                req_type,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0]    setpoint,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0]    measurement,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0]    actual_output,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    drive,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    p_term,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    i_term,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]    d_term
);

  pidc_pkg::dp_ctl_t  ctl;
  pidc_pkg::dp_stat_t stat;

  pidc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  pidc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .setpoint      (setpoint),
    .measurement   (measurement),
    .actual_output (actual_output),
    .drive         (drive),
    .p_term        (p_term),
    .i_term        (i_term),
    .d_term        (d_term)
  );

endmodule

>>> tb/sv/tb_pid_controller_step.sv
// tb_pid_controller_step.sv: self-checking bench for the Q16.16 PID step block.
// Drives random and directed items, predicts every result item in place and
// compares field by field. Depends on pidc_pkg and pid_controller_step.
`timescale 1ns / 1ps

module tb_pid_controller_step;
  import pidc_pkg::*;

  localparam int           DW          = DATA_WIDTH;
  localparam longint       Q_MAX       = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint       Q_MIN       = -Q_MAX - 1;
  localparam logic [1:0]   REQ_SPARE   = 2'd3;
  localparam int           HOLD_CYCLES = 150;
  localparam int           CYCLE_LIMIT = 300000;
  localparam int           N_PHASES    = 6;
  localparam int           PHASE_ITEMS = 130;

  typedef struct packed {
    logic [1:0]           req;
    logic signed [DW-1:0] sp;
    logic signed [DW-1:0] meas;
    logic signed [DW-1:0] act;
  } pid_item_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic signed [DW-1:0] p;
    logic signed [DW-1:0] i;
    logic signed [DW-1:0] d;
  } pid_result_t;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     cfg_we        = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index     = '0;
  logic [DW-1:0]            cfg_data      = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [1:0]               req_type      = '0;
  logic signed [DW-1:0]     setpoint      = '0;
  logic signed [DW-1:0]     measurement   = '0;
  logic signed [DW-1:0]     actual_output = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic signed [DW-1:0]     drive;
  logic signed [DW-1:0]     p_term;
  logic signed [DW-1:0]     i_term;
  logic signed [DW-1:0]     d_term;

  pid_controller_step dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .setpoint      (setpoint),
    .measurement   (measurement),
    .actual_output (actual_output),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .p_term        (p_term),
    .i_term        (i_term),
    .d_term        (d_term)
  );

  always #2 clk = ~clk;

  // predictor copy of the gains, clamps and loop state
  longint g_kp = 0, g_ki = 0, g_dg = 0, g_dp = 0, g_tg = 0;
  longint lim_lo = Q_MIN, lim_hi = Q_MAX, int_lim = Q_MAX;
  longint integ_acc = 0, last_err = 0, last_meas = 0;
  longint deriv_acc = 0, prop_acc = 0, drive_hold = 0;

  pid_item_t   pend_items[$];
  pid_result_t drive_expect[$];
  pid_item_t   cur_item;
  int          n_left        = 0;
  int          n_err         = 0;
  int          n_cycles      = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left     = 0;
  bit          hold_arm      = 1'b0;
  logic signed [DW-1:0] track_sp = '0;

  function automatic longint sat_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint clamp_integ(input longint v);
    if (v > int_lim) return int_lim;
    if (v < -int_lim) return -int_lim;
    return v;
  endfunction

  // exact product, shift by FRAC_BITS rounding half away from zero, saturate
  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] ax, bx, pr;
    logic [127:0]        m, q;
    ax = a;
    bx = b;
    pr = ax * bx;
    if (pr < 0) m = -pr;
    else m = pr;
    q = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (pr < 0) begin
      if (q > 128'(Q_MAX) + 1) return Q_MIN;
      return -longint'(q);
    end
    if (q > 128'(Q_MAX)) return Q_MAX;
    return longint'(q);
  endfunction

  function automatic pid_result_t pid_next(input pid_item_t it);
    longint      sp, meas, err, dn, drv, lo, hi;
    pid_result_t r;
    case (it.req)
      REQ_UPDATE: begin
        sp = it.sp;
        meas = it.meas;
        err = sat_q(sp - meas);
        integ_acc = clamp_integ(sat_q(integ_acc + fx_mul(g_ki, err + last_err)));
        if (g_dg == 0) dn = 0;
        else dn = sat_q(-fx_mul(g_dg, meas - last_meas) - fx_mul(g_dp, deriv_acc));
        deriv_acc = dn;
        prop_acc = fx_mul(g_kp, err);
        drv = sat_q(prop_acc + integ_acc + dn);
        lo = lim_lo;
        hi = lim_hi;
        if (lo > hi) begin
          lo = lim_hi;
          hi = lim_lo;
        end
        if (drv > hi) drv = hi;
        if (drv < lo) drv = lo;
        drive_hold = drv;
        last_err = err;
        last_meas = meas;
      end
      REQ_TRACK: begin
        if (g_tg > 0)
          integ_acc = clamp_integ(sat_q(integ_acc + fx_mul(g_tg, longint'(it.act) - drive_hold)));
      end
      REQ_CLEAR: begin
        integ_acc = 0;
        last_err = 0;
        last_meas = 0;
        deriv_acc = 0;
        prop_acc = 0;
        drive_hold = 0;
      end
      default: ;
    endcase
    r.drive = drive_hold[DW-1:0];
    r.p = prop_acc[DW-1:0];
    r.i = integ_acc[DW-1:0];
    r.d = deriv_acc[DW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    n_err++;
    if (n_err <= 100)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
  endtask

  // item driver
  always @(posedge clk) begin : feed
    pid_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        drive_expect.push_back(pid_next(cur_item));
        n_left--;
      end
      if (!in_valid || !in_stall) begin
        if (pend_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pend_items.pop_front();
          cur_item = nxt;
          in_valid <= 1'b1;
          req_type <= nxt.req;
          setpoint <= nxt.sp;
          measurement <= nxt.meas;
          actual_output <= nxt.act;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_arm || hold_left > 0) begin
      if (hold_arm) begin
        hold_arm = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    pid_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (drive_expect.size() == 0) begin
        report_mismatch("unexpected result, drive", drive, 0);
      end else begin
        e = drive_expect.pop_front();
        if (drive !== e.drive) report_mismatch("drive", drive, e.drive);
        if (p_term !== e.p) report_mismatch("p_term", p_term, e.p);
        if (i_term !== e.i) report_mismatch("i_term", i_term, e.i);
        if (d_term !== e.d) report_mismatch("d_term", d_term, e.d);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_pid_controller_step: FAIL");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_KP:            g_kp = longint'($signed(val));
      CFG_KI_HALF_T:     g_ki = longint'($signed(val));
      CFG_D_GAIN:        g_dg = longint'($signed(val));
      CFG_D_POLE:        g_dp = longint'($signed(val));
      CFG_TRACKING_GAIN: g_tg = longint'($signed(val));
      CFG_OUT_MIN:       lim_lo = longint'($signed(val));
      CFG_OUT_MAX:       lim_hi = longint'($signed(val));
      CFG_INT_LIMIT:     int_lim = longint'(val[DW-2:0]);
      default: ;
    endcase
  endtask

  task automatic cfg_end();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_left != 0 || drive_expect.size() != 0) @(posedge clk);
  endtask

  task automatic push_item(input logic [1:0] rq, input logic signed [DW-1:0] sp,
                           input logic signed [DW-1:0] ms, input logic signed [DW-1:0] ac);
    pid_item_t it;
    it.req = rq;
    it.sp = sp;
    it.meas = ms;
    it.act = ac;
    pend_items.push_back(it);
    n_left++;
  endtask

  function automatic logic signed [DW-1:0] corner_value();
    case ($urandom_range(4))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3: return 1;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return $signed($urandom) >>> 9;
    if (sel < 8) return $urandom;
    return corner_value();
  endfunction

  function automatic logic signed [DW-1:0] pick_gain();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom_range(32'h30000);
    if (sel < 6) return $signed($urandom) >>> 13;
    if (sel == 6) return -$urandom_range(32'h20000);
    if (sel < 9) return $urandom;
    return corner_value();
  endfunction

  // mostly closed-loop style updates around a slowly moving setpoint
  function automatic pid_item_t gen_item();
    pid_item_t   it;
    int unsigned r;
    r = $urandom_range(99);
    if ($urandom_range(9) == 0) track_sp = pick_sample();
    it.sp = track_sp;
    if ($urandom_range(9) < 7) it.meas = track_sp + ($signed($urandom) >>> 14);
    else it.meas = pick_sample();
    it.act = pick_sample();
    if (r < 78) it.req = REQ_UPDATE;
    else if (r < 90) it.req = REQ_TRACK;
    else if (r < 96) it.req = REQ_CLEAR;
    else it.req = REQ_SPARE;
    return it;
  endfunction

  task automatic config_random();
    logic signed [DW-1:0] lo, hi, lim;
    case ($urandom_range(5))
      0, 1, 2: begin
        lo = -$urandom_range(32'h01000000);
        hi = $urandom_range(32'h01000000);
      end
      3: begin
        lo = $urandom_range(32'h00800000);
        hi = -$urandom_range(32'h00800000);
      end
      4: begin
        lo = VMIN;
        hi = VMAX;
      end
      default: begin
        lo = $urandom;
        hi = $urandom;
      end
    endcase
    case ($urandom_range(5))
      0, 1, 2: lim = $urandom_range(32'h01000000);
      3:       lim = 32'h7fffffff;
      4:       lim = '0;
      default: lim = $urandom >> 1;
    endcase
    cfg_write(CFG_KP, pick_gain());
    cfg_write(CFG_KI_HALF_T, pick_gain());
    cfg_write(CFG_D_GAIN, pick_gain());
    cfg_write(CFG_D_POLE, pick_gain());
    cfg_write(CFG_TRACKING_GAIN, pick_gain());
    cfg_write(CFG_OUT_MIN, lo);
    cfg_write(CFG_OUT_MAX, hi);
    cfg_write(CFG_INT_LIMIT, lim);
    cfg_end();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 78;

    cfg_write(CFG_KP, 32'h10000);
    cfg_write(CFG_KI_HALF_T, 32'h8000);
    cfg_write(CFG_D_GAIN, 32'h20000);
    cfg_write(CFG_D_POLE, 32'h4000);
    cfg_write(CFG_TRACKING_GAIN, 32'h1000);
    cfg_write(CFG_OUT_MIN, -32'sh640000);
    cfg_write(CFG_OUT_MAX, 32'sh640000);
    cfg_write(CFG_INT_LIMIT, 32'h320000);
    cfg_end();
    push_item(REQ_UPDATE, 32'sh10000, 0, 0);
    push_item(REQ_UPDATE, VMAX, VMIN, 0);
    push_item(REQ_UPDATE, VMIN, VMAX, 0);
    push_item(REQ_UPDATE, 0, 0, 0);
    push_item(REQ_UPDATE, -1, 1, 0);
    push_item(REQ_TRACK, 0, 0, VMAX);
    push_item(REQ_TRACK, 0, 0, VMIN);
    push_item(REQ_SPARE, VMAX, VMIN, -1);
    push_item(REQ_CLEAR, VMIN, VMAX, VMAX);
    push_item(REQ_UPDATE, 32'sh28000, 32'sh18000, 0);

    // smaller integrator limit over old state, swapped clamps, tracking off,
    // rounding ties, derivative off
    wait_drained();
    cfg_write(CFG_KP, 32'h8000);
    cfg_write(CFG_TRACKING_GAIN, 0);
    cfg_write(CFG_INT_LIMIT, 32'h8000);
    cfg_write(CFG_OUT_MIN, 32'sh10000);
    cfg_write(CFG_OUT_MAX, -32'sh10000);
    cfg_write(CFG_D_GAIN, 0);
    cfg_end();
    push_item(REQ_TRACK, 0, 0, 32'sh7fff);
    push_item(REQ_UPDATE, 1, 0, 0);
    push_item(REQ_UPDATE, -1, 0, 0);
    push_item(REQ_UPDATE, 3, 0, 0);
    push_item(REQ_UPDATE, 32'sh40000, -32'sh40000, 0);
    push_item(REQ_TRACK, 0, 0, VMIN);

    // extreme gains, zero integrator limit, negative tracking gain
    wait_drained();
    cfg_write(CFG_KP, VMIN);
    cfg_write(CFG_KI_HALF_T, VMAX);
    cfg_write(CFG_D_GAIN, VMAX);
    cfg_write(CFG_D_POLE, VMIN);
    cfg_write(CFG_TRACKING_GAIN, '1);
    cfg_write(CFG_OUT_MIN, VMIN);
    cfg_write(CFG_OUT_MAX, VMAX);
    cfg_write(CFG_INT_LIMIT, 0);
    cfg_end();
    push_item(REQ_UPDATE, VMAX, VMIN, 0);
    push_item(REQ_UPDATE, VMIN, VMAX, 0);
    push_item(REQ_TRACK, 0, 0, VMIN);
    push_item(REQ_UPDATE, 0, 0, 0);
    push_item(REQ_CLEAR, 0, 0, 0);

    wait_drained();
    cfg_write(CFG_KP, VMAX);
    cfg_write(CFG_KI_HALF_T, VMIN);
    cfg_write(CFG_D_GAIN, VMIN);
    cfg_write(CFG_D_POLE, VMAX);
    cfg_write(CFG_TRACKING_GAIN, VMAX);
    cfg_write(CFG_OUT_MIN, VMAX);
    cfg_write(CFG_OUT_MAX, VMIN);
    cfg_write(CFG_INT_LIMIT, 32'h7fffffff);
    cfg_end();
    push_item(REQ_UPDATE, 32'sh12345678, -32'sh12345678, 0);
    push_item(REQ_TRACK, 0, 0, VMAX);
    push_item(REQ_TRACK, 0, 0, VMIN);
    push_item(REQ_UPDATE, -1, 0, 0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      config_random();
      if (ph < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 78;
      end else if (ph < 4) begin
        send_idle_pct = 78;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) pend_items.push_back(gen_item());
      n_left += PHASE_ITEMS;
      if (ph == N_PHASES - 2) hold_arm = 1'b1;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_pid_controller_step: PASS");
    end else begin
      $display("tb_pid_controller_step: FAIL");
    end
    $finish;
  end

endmodule
